### design/ial_pkg.sv
// shared types and constants for the indexed array list engine
package ial_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 9;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 9;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_READ    = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REPLACE = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_WRITE_NEW,
    S_RESULT
  } state_t;

endpackage

### design/indexed_array_list_engine.sv
// indexed array list engine: ordered list store with insert and remove by index
// sequence: append, read, replace and errors pass from execute straight to the result state;
//   insert moves later entries up one place, then writes the new item; remove moves them down one
// throughput: one request at a time; the store reads one entry and writes one per cycle,
//   and a result held by m_tready keeps the next request waiting
// reset: rst clears the length, the sequencer and the output valid; store stays undefined
module indexed_array_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [ial_pkg::IN_W-1:0] s_tdata,   // opcode, position, item_value
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [ial_pkg::OUT_W-1:0] m_tdata   // status, read_value, current_length
);
  import ial_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;

  state_t              state, state_next;
  logic [OPCODE_W-1:0] op;
  logic [POS_W-1:0]    pos;
  logic [VALUE_W-1:0]  val;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       src, src_next;
  status_t             stat, stat_next;
  logic [VALUE_W-1:0]  rdv, rdv_next;
  logic                take_mem, take_mem_next;

  logic               wr_en, rd_en, load;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [EW-1:0]      pos_ext, cnt_ext;
  logic [AW-1:0]      pos_a, cnt_a;
  logic               full;

  assign pos_ext  = EW'(pos);
  assign cnt_ext  = EW'(count);
  assign pos_a    = pos_ext[AW-1:0];
  assign cnt_a    = cnt_ext[AW-1:0];
  assign full     = (count == CW'(CAPACITY));
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    src_next      = src;
    stat_next     = stat;
    rdv_next      = rdv;
    take_mem_next = take_mem;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = val;
    rd_en         = 1'b0;
    rd_addr       = '0;
    load          = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        stat_next     = ST_OK;
        rdv_next      = '0;
        take_mem_next = 1'b0;
        state_next    = S_RESULT;
        case (op)
          OP_APPEND: begin
            if (full) begin
              stat_next = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = cnt_a;
              count_next = count + CW'(1);
            end
          end
          OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
              stat_next = ST_RANGE;
            end else if (full) begin
              stat_next = ST_FULL;
            end else if (pos_ext == cnt_ext) begin
              wr_en      = 1'b1;
              wr_addr    = pos_a;
              count_next = count + CW'(1);
            end else begin
              rd_en      = 1'b1;
              rd_addr    = cnt_a - AW'(1);
              src_next   = cnt_a - AW'(1);
              state_next = S_SHIFT;
            end
          end
          OP_READ: begin
            if (pos_ext >= cnt_ext) begin
              stat_next = ST_RANGE;
              rdv_next  = '1;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = pos_a;
              take_mem_next = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
              stat_next = ST_RANGE;
            end else if (pos_ext + EW'(1) == cnt_ext) begin
              count_next = count - CW'(1);
            end else begin
              rd_en      = 1'b1;
              rd_addr    = pos_a + AW'(1);
              src_next   = pos_a + AW'(1);
              state_next = S_SHIFT;
            end
          end
          OP_REPLACE: begin
            if (pos_ext >= cnt_ext) begin
              stat_next = ST_RANGE;
            end else begin
              wr_en   = 1'b1;
              wr_addr = pos_a;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rdata;
        if (op == OP_INSERT) begin
          wr_addr = src + AW'(1);
          if (src == pos_a) begin
            state_next = S_WRITE_NEW;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = src - AW'(1);
            src_next = src - AW'(1);
          end
        end else begin
          wr_addr = src - AW'(1);
          if (EW'(src) + EW'(1) == cnt_ext) begin
            count_next = count - CW'(1);
            state_next = S_RESULT;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = src + AW'(1);
            src_next = src + AW'(1);
          end
        end
      end
      S_WRITE_NEW: begin
        wr_en      = 1'b1;
        wr_addr    = pos_a;
        count_next = count + CW'(1);
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op  <= s_tdata[OPCODE_W-1:0];
      pos <= s_tdata[OPCODE_W +: POS_W];
      val <= s_tdata[OPCODE_W+POS_W +: VALUE_W];
    end
    src      <= src_next;
    stat     <= stat_next;
    rdv      <= rdv_next;
    take_mem <= take_mem_next;
    if (load) begin
      m_tdata <= {(OUT_W - LEN_W - VALUE_W - STATUS_W)'(0), LEN_W'(count),
                  take_mem ? rdata : rdv, stat};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("list length above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == S_EXEC || $past(state) == S_SHIFT ||
                                 $past(state) == S_WRITE_NEW))
    else $error("list length changed outside a request");

  assert property (@(posedge clk) disable iff (rst)
    $past(load) |-> (m_tvalid && m_tdata[STATUS_W+VALUE_W +: LEN_W] == LEN_W'(count)))
    else $error("reported length differs from list length");

endmodule
